>>> rtl/tpwa_pkg.sv
// shared types, coefficient table and constants of the triangle polynomial warp address block
// no dependencies; imported by every module under rtl
package tpwa_pkg;

  localparam int CoordW       = 10;
  localparam int CfgW         = 11;
  localparam int CfgIdxW      = 1;
  localparam int RegionW      = 3;
  localparam int CoordBitsDef = 10;
  localparam int CoefW        = 36;
  localparam int FracBits     = 34;
  localparam int SumW         = 50;
  localparam int RndW         = SumW - FracBits;
  localparam int LinW         = CoefW + CoordW + 1;
  localparam int QuadW        = CoefW + 2 * CoordW + 1;

  localparam logic [CfgW-1:0] WidthRst  = CfgW'(328);
  localparam logic [CfgW-1:0] HeightRst = CfgW'(328);

  localparam logic signed [SumW-1:0] RoundHalf   = SumW'(1) <<< (FracBits - 1);
  localparam logic signed [SumW-1:0] RoundHalfM1 = RoundHalf - SumW'(1);

  // coefficients, 34 fraction bits
  localparam logic signed [CoefW-1:0] KA = 36'sd3730059882;
  localparam logic signed [CoefW-1:0] KB = 36'sd13449809302;
  localparam logic signed [CoefW-1:0] KC = 36'sd41638704;
  localparam logic signed [CoefW-1:0] KD = 36'sd507789;
  localparam logic signed [CoefW-1:0] KE = 36'sd41130915;
  localparam logic signed [CoefW-1:0] KF = 36'sd30465656413;
  localparam logic signed [CoefW-1:0] KG = 36'sd13285787238;
  localparam logic signed [CoefW-1:0] KP = 36'sd40629319;
  localparam logic signed [CoefW-1:0] KQ = 36'sd501597;
  localparam logic signed [CoefW-1:0] KR = 36'sd1015578;
  localparam logic signed [CoefW-1:0] KS = 36'sd42146493;

  typedef enum logic [RegionW-1:0] {
    REG_TOP      = 3'd0,
    REG_BOTTOM   = 3'd1,
    REG_LEFT_UP  = 3'd2,
    REG_LEFT_LO  = 3'd3,
    REG_RIGHT_UP = 3'd4,
    REG_RIGHT_LO = 3'd5
  } region_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 1'd0,
    CFG_HEIGHT = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [CoordW-1:0] out_row;
    logic [CoordW-1:0] out_col;
  } in_req_t;

  typedef struct packed {
    logic [CoordW-1:0]  src_row;
    logic [CoordW-1:0]  src_col;
    logic [RegionW-1:0] region;
    logic               clamped;
  } out_req_t;

  typedef struct packed {
    region_e           region;
    logic [CoordW-1:0] i;
    logic [CoordW-1:0] j;
    logic              hit;
  } meta_t;

  typedef struct packed {
    meta_t                  meta;
    logic signed [RndW-1:0] val;
  } poly_t;

  typedef struct packed {
    logic signed [CoefW-1:0] k_i;
    logic signed [CoefW-1:0] k_j;
    logic signed [CoefW-1:0] k_ii;
    logic signed [CoefW-1:0] k_ij;
    logic signed [CoefW-1:0] k_jj;
  } coef_t;

  function automatic coef_t coef_of(input region_e rg);
    coef_t c;
    case (rg)
      REG_TOP:      c = '{KA, KB, KC, -KD, -KE};
      REG_BOTTOM:   c = '{KF, -KG, -KP, -KQ, KE};
      REG_LEFT_UP:  c = '{KB, KA, -KE, -KD, KC};
      REG_LEFT_LO:  c = '{KB, KA, -KE, -KR, KS};
      REG_RIGHT_UP: c = '{-KG, KF, KE, -KQ, -KP};
      REG_RIGHT_LO: c = '{-KG, KF, KE, -KQ, -KP};
      default:      c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/tpwa_region.sv
// first pipeline stage: saturates the pixel to the image and picks its triangular region
// depends on tpwa_pkg
module tpwa_region import tpwa_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  in_req_t               req_i,
  input  logic [COORD_BITS:0]   img_w_i,
  input  logic [COORD_BITS:0]   img_h_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output meta_t                 meta_o
);

  localparam int DimW = COORD_BITS + 1;
  localparam int CmpW = ((DimW > CoordW) ? DimW : CoordW) + 2;

  logic [CmpW-1:0] iw, jw, wx, hx, h2, w2, r;
  logic            hit;
  region_e         rg;
  meta_t           meta_d, meta_q;
  logic            valid_q;
  logic            ld;

  assign ld      = !valid_q || ready_i;
  assign ready_o = ld;
  assign valid_o = valid_q;
  assign meta_o  = meta_q;

  always_comb begin
    wx  = CmpW'(img_w_i);
    hx  = CmpW'(img_h_i);
    iw  = CmpW'(req_i.out_row);
    jw  = CmpW'(req_i.out_col);
    hit = 1'b0;
    if (iw >= hx) begin
      iw  = hx - CmpW'(1);
      hit = 1'b1;
    end
    if (jw >= wx) begin
      jw  = wx - CmpW'(1);
      hit = 1'b1;
    end
    h2 = hx >> 1;
    w2 = wx >> 1;
    r  = '0;
    rg = REG_TOP;
    if (iw < h2) begin
      if (jw >= iw && jw + iw < wx) rg = REG_TOP;
      if (jw <= iw) rg = REG_LEFT_UP;
      if (jw + iw + CmpW'(1) >= wx) rg = REG_RIGHT_UP;
    end else begin
      r = iw - h2;
      if (jw + r >= w2 && jw <= w2 + r) rg = REG_BOTTOM;
      if (jw + r <= w2) rg = REG_LEFT_LO;
      if (jw >= w2 + r) rg = REG_RIGHT_LO;
    end
    meta_d.region = rg;
    meta_d.i      = CoordW'(iw);
    meta_d.j      = CoordW'(jw);
    meta_d.hit    = hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ld) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld && valid_i) begin
      meta_q <= meta_d;
    end
  end

  // pixel outside the image must be flagged
  a_out_of_image_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && (CmpW'(req_i.out_row) >= CmpW'(img_h_i) ||
                           CmpW'(req_i.out_col) >= CmpW'(img_w_i))
    |=> meta_q.hit)
    else $error("out of image request not flagged");

endmodule

>>> rtl/tpwa_poly.sv
// polynomial pipeline: squares, coefficient products, adder tree and rounding
// depends on tpwa_pkg for the coefficient table and the shared types
module tpwa_poly import tpwa_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  meta_t  meta_i,
  output logic   valid_o,
  input  logic   ready_i,
  output poly_t  poly_o
);

  localparam int NumStg = 5;

  logic [NumStg-1:0] v_q;
  logic [NumStg:0]   ld;
  meta_t             meta_q [NumStg];

  coef_t c0, c1;

  logic [2*CoordW-1:0]     sq_ii_q, sq_jj_q, sq_ij_q;
  logic signed [LinW-1:0]  pi_d, pj_d, pi_q, pj_q;
  logic signed [QuadW-1:0] pii_d, pij_d, pjj_d;
  logic signed [SumW-1:0]  lin_q, pii_q, pij_q, pjj_q;
  logic signed [SumW-1:0]  a_q, b_q, s_q, rnd_d;
  logic signed [RndW-1:0]  rnd_q;

  always_comb begin
    ld[NumStg] = ready_i;
    for (int k = NumStg - 1; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  assign ready_o = ld[0];
  assign valid_o = v_q[NumStg-1];
  assign poly_o  = '{meta: meta_q[NumStg-1], val: rnd_q};

  assign c0    = coef_of(meta_i.region);
  assign pi_d  = c0.k_i * $signed({1'b0, meta_i.i});
  assign pj_d  = c0.k_j * $signed({1'b0, meta_i.j});

  assign c1    = coef_of(meta_q[0].region);
  assign pii_d = c1.k_ii * $signed({1'b0, sq_ii_q});
  assign pij_d = c1.k_ij * $signed({1'b0, sq_ij_q});
  assign pjj_d = c1.k_jj * $signed({1'b0, sq_jj_q});

  // half away from zero: negative sums round with half minus one, then floor
  assign rnd_d = s_q + (s_q[SumW-1] ? RoundHalfM1 : RoundHalf);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NumStg; k++) begin
        if (ld[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      meta_q[0] <= meta_i;
      sq_ii_q   <= meta_i.i * meta_i.i;
      sq_jj_q   <= meta_i.j * meta_i.j;
      sq_ij_q   <= meta_i.i * meta_i.j;
      pi_q      <= pi_d;
      pj_q      <= pj_d;
    end
    if (ld[1]) begin
      meta_q[1] <= meta_q[0];
      lin_q     <= SumW'(pi_q) + SumW'(pj_q);
      pii_q     <= SumW'(pii_d);
      pij_q     <= SumW'(pij_d);
      pjj_q     <= SumW'(pjj_d);
    end
    if (ld[2]) begin
      meta_q[2] <= meta_q[1];
      a_q       <= lin_q + pii_q;
      b_q       <= pij_q + pjj_q;
    end
    if (ld[3]) begin
      meta_q[3] <= meta_q[2];
      s_q       <= a_q + b_q;
    end
    if (ld[4]) begin
      meta_q[4] <= meta_q[3];
      rnd_q     <= rnd_d[SumW-1:FracBits];
    end
  end

  a_enter_first_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> v_q[0])
    else $error("accepted request missing from first stage");

  a_first_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !ld[1] |=> v_q[0] && $stable(meta_q[0]))
    else $error("stalled first stage lost its request");

endmodule

>>> rtl/tpwa_clamp.sv
// last stage: clamps the rounded value to the image and drives the output register
// depends on tpwa_pkg
module tpwa_clamp import tpwa_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  poly_t               poly_i,
  input  logic [COORD_BITS:0] img_w_i,
  input  logic [COORD_BITS:0] img_h_i,
  output logic                valid_o,
  input  logic                ready_i,
  output out_req_t            res_o
);

  localparam int DimW = COORD_BITS + 1;

  logic            row_side;
  logic [DimW-1:0] dim;
  logic [DimW-1:0] cl;
  logic            hit;
  out_req_t        res_d, res_q;
  logic            valid_q;
  logic            ld;

  assign ld      = !valid_q || ready_i;
  assign ready_o = ld;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    row_side = (poly_i.meta.region == REG_TOP) || (poly_i.meta.region == REG_BOTTOM);
    dim      = row_side ? img_h_i : img_w_i;
    hit      = 1'b0;
    if (poly_i.val[RndW-1]) begin
      cl  = '0;
      hit = 1'b1;
    end else if ($unsigned(poly_i.val) >= RndW'(dim)) begin
      cl  = dim - DimW'(1);
      hit = 1'b1;
    end else begin
      cl  = DimW'($unsigned(poly_i.val));
    end
    res_d.src_row = row_side ? CoordW'(cl) : poly_i.meta.i;
    res_d.src_col = row_side ? poly_i.meta.j : CoordW'(cl);
    res_d.region  = poly_i.meta.region;
    res_d.clamped = poly_i.meta.hit || hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ld) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld && valid_i) begin
      res_q <= res_d;
    end
  end

  a_negative_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && poly_i.val[RndW-1] |=> res_q.clamped)
    else $error("negative polynomial value not flagged");

endmodule

>>> rtl/triangle_poly_warp_address.sv
// top level of the triangle polynomial warp address generator: config registers and pipeline
// depends on tpwa_pkg, tpwa_region, tpwa_poly and tpwa_clamp
//
//   channel   signals                                   direction
//   in        in_valid_i / in_ready_o / in_req_i        request in (out_row, out_col)
//   out       out_valid_o / out_ready_i / out_res_o     request out (src_row, src_col, region, clamped)
//   cfg       cfg_we_i / cfg_idx_i / cfg_wdata_i        register write, no wait
//
// one request per cycle sustained while the output is not stalled; requests pass through the region stage,
// five polynomial stages (squares, products, two adder levels, rounding) and the clamp stage
// each stage holds its request while the next stage cannot take it, empty stages fill while the output stalls
// reset clears every valid bit and loads 328 into both dimension registers
module triangle_poly_warp_address import tpwa_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_req_t              in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_req_t             out_res_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_wdata_i
);

  localparam int DimW = COORD_BITS + 1;
  localparam int ExtW = (CfgW > DimW) ? CfgW : DimW;

  logic [CfgW-1:0] width_q, height_q;
  logic [DimW-1:0] img_w, img_h;

  logic  reg_valid, reg_ready;
  meta_t reg_meta;
  logic  poly_valid, poly_ready;
  poly_t poly_res;

  // saturate a dimension to 2 .. 2^COORD_BITS
  function automatic logic [DimW-1:0] eff_dim(input logic [CfgW-1:0] v);
    logic [ExtW-1:0] x;
    logic [ExtW-1:0] max_d;
    x     = ExtW'(v);
    max_d = ExtW'(1) << COORD_BITS;
    if (x < ExtW'(2)) x = ExtW'(2);
    if (x > max_d) x = max_d;
    return DimW'(x);
  endfunction

  assign img_w = eff_dim(width_q);
  assign img_h = eff_dim(height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tpwa_region #(
    .COORD_BITS(COORD_BITS)
  ) u_region (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .req_i   (in_req_i),
    .img_w_i (img_w),
    .img_h_i (img_h),
    .valid_o (reg_valid),
    .ready_i (reg_ready),
    .meta_o  (reg_meta)
  );

  tpwa_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (reg_valid),
    .ready_o (reg_ready),
    .meta_i  (reg_meta),
    .valid_o (poly_valid),
    .ready_i (poly_ready),
    .poly_o  (poly_res)
  );

  tpwa_clamp #(
    .COORD_BITS(COORD_BITS)
  ) u_clamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (poly_valid),
    .ready_o (poly_ready),
    .poly_i  (poly_res),
    .img_w_i (img_w),
    .img_h_i (img_h),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (out_res_o)
  );

  // an empty output register means no stage can be blocked
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

endmodule

>>> verif/tb_triangle_poly_warp_address.sv
`timescale 1ns / 100ps
// testbench for triangle_poly_warp_address: directed corner pixels, then random pixel
// streams under several image sizes, checked against an in-bench fixed-point warp predictor
// depends on tpwa_pkg and the rtl top level only
module tb_triangle_poly_warp_address;
  import tpwa_pkg::*;

  localparam longint CoefA = 64'sd3730059882;
  localparam longint CoefB = 64'sd13449809302;
  localparam longint CoefC = 64'sd41638704;
  localparam longint CoefD = 64'sd507789;
  localparam longint CoefE = 64'sd41130915;
  localparam longint CoefF = 64'sd30465656413;
  localparam longint CoefG = 64'sd13285787238;
  localparam longint CoefP = 64'sd40629319;
  localparam longint CoefQ = 64'sd501597;
  localparam longint CoefR = 64'sd1015578;
  localparam longint CoefS = 64'sd42146493;
  localparam int     Frac  = 34;
  localparam longint Half  = 64'sd1 <<< (Frac - 1);
  localparam int     MaxDim = 1 << CoordBitsDef;
  localparam int     DrainCycles = 12;
  localparam int     RandPerPhase = 230;
  localparam int     NumPhases = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_req_t             in_req_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_req_t            out_res_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;

  in_req_t     pixel_q [$];
  out_req_t    src_addr_q [$];
  out_req_t    want_res;
  logic [CfgW-1:0] width_reg = WidthRst;
  logic [CfgW-1:0] height_reg = HeightRst;
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 88;
  int unsigned fail_cnt = 0;
  logic        out_hold = 1'b0;
  bit          holdoff_go = 1'b0;

  triangle_poly_warp_address uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint sat_dim(logic [CfgW-1:0] v);
    longint d;
    d = v;
    if (d < 2) d = 2;
    if (d > MaxDim) d = MaxDim;
    return d;
  endfunction

  function automatic out_req_t predict_src_addr(in_req_t px, logic [CfgW-1:0] wreg,
                                                logic [CfgW-1:0] hreg);
    longint w, h, i, j, h2, w2, r, s, v, lim;
    region_e rg;
    logic hit, row_map;
    out_req_t res;
    w = sat_dim(wreg);
    h = sat_dim(hreg);
    i = px.out_row;
    j = px.out_col;
    hit = 1'b0;
    if (i >= h) begin
      i = h - 1;
      hit = 1'b1;
    end
    if (j >= w) begin
      j = w - 1;
      hit = 1'b1;
    end
    h2 = h / 2;
    w2 = w / 2;
    rg = REG_TOP;
    if (i < h2) begin
      if (j <= i) rg = REG_LEFT_UP;
      if (j + i + 1 >= w) rg = REG_RIGHT_UP;
    end else begin
      r = i - h2;
      if (j + r >= w2 && j <= w2 + r) rg = REG_BOTTOM;
      if (j + r <= w2) rg = REG_LEFT_LO;
      if (j >= w2 + r) rg = REG_RIGHT_LO;
    end
    case (rg)
      REG_TOP:     s = CoefA*i + CoefB*j + CoefC*i*i - CoefD*i*j - CoefE*j*j;
      REG_BOTTOM:  s = CoefF*i - CoefG*j - CoefP*i*i - CoefQ*i*j + CoefE*j*j;
      REG_LEFT_UP: s = CoefB*i + CoefA*j - CoefE*i*i - CoefD*i*j + CoefC*j*j;
      REG_LEFT_LO: s = CoefB*i + CoefA*j - CoefE*i*i - CoefR*i*j + CoefS*j*j;
      default:     s = -CoefG*i + CoefF*j + CoefE*i*i - CoefQ*i*j - CoefP*j*j;
    endcase
    // round half away from zero
    v = (s >= 0) ? ((s + Half) >>> Frac) : -((-s + Half) >>> Frac);
    row_map = (rg == REG_TOP) || (rg == REG_BOTTOM);
    lim = row_map ? h : w;
    if (v < 0) begin
      v = 0;
      hit = 1'b1;
    end else if (v > lim - 1) begin
      v = lim - 1;
      hit = 1'b1;
    end
    res.src_row = row_map ? v[CoordW-1:0] : i[CoordW-1:0];
    res.src_col = row_map ? j[CoordW-1:0] : v[CoordW-1:0];
    res.region  = rg;
    res.clamped = hit;
    return res;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        src_addr_q.push_back(predict_src_addr(in_req_i, width_reg, height_reg));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_req_i   <= pixel_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (src_addr_q.size() == 0) begin
          $error("unexpected request: src_row %0d src_col %0d", out_res_o.src_row,
                 out_res_o.src_col);
          fail_cnt++;
        end else begin
          want_res = src_addr_q.pop_front();
          compare_field("src_row", want_res.src_row, out_res_o.src_row);
          compare_field("src_col", want_res.src_col, out_res_o.src_col);
          compare_field("region", want_res.region, out_res_o.region);
          compare_field("clamped", want_res.clamped, out_res_o.clamped);
        end
      end
      out_ready_i <= !out_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall so the pipeline backs up into the input
  initial begin
    wait (holdoff_go);
    @(posedge clk_i);
    out_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    out_hold <= 1'b0;
  end

  initial begin
    #(12 * 200000);
    $display("tb_triangle_poly_warp_address NOT OK");
    $finish;
  end

  task automatic push_pixel(int r, int c);
    in_req_t px;
    if (r < 0) r = 0;
    if (r > 1023) r = 1023;
    if (c < 0) c = 0;
    if (c > 1023) c = 1023;
    px.out_row = r[CoordW-1:0];
    px.out_col = c[CoordW-1:0];
    pixel_q.push_back(px);
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid_i || src_addr_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_dims(logic [CfgW-1:0] w, logic [CfgW-1:0] h);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    width_reg  = w;
    height_reg = h;
  endtask

  initial begin
    logic [CfgW-1:0] cfg_w [NumPhases];
    logic [CfgW-1:0] cfg_h [NumPhases];
    int wd, hd, r, c, k;
    cfg_w = '{11'd328, 11'd2, 11'd1024, 11'd0, 11'd1, 11'd17, 11'd1000, 11'd0};
    cfg_h = '{11'd328, 11'd2, 11'd1024, 11'd2047, 11'd1025, 11'd600, 11'd40, 11'd0};
    cfg_w[NumPhases-1] = CfgW'($urandom_range(2047));
    cfg_h[NumPhases-1] = CfgW'($urandom_range(2047));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners, region boundaries and off-image pixels at the reset size
    push_pixel(0, 0);
    push_pixel(1023, 1023);
    push_pixel(0, 1023);
    push_pixel(1023, 0);
    push_pixel(163, 163);
    push_pixel(163, 164);
    push_pixel(164, 164);
    push_pixel(164, 163);
    push_pixel(200, 128);
    push_pixel(200, 200);
    push_pixel(200, 164);
    push_pixel(327, 327);
    push_pixel(327, 0);
    push_pixel(0, 327);
    push_pixel(163, 0);
    push_pixel(163, 327);
    push_pixel(328, 100);
    push_pixel(100, 328);
    push_pixel(341, 682);
    push_pixel(682, 341);
    push_pixel(100, 50);
    push_pixel(50, 280);
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 88;
      end else if (ph < 6) begin
        send_idle_pct = 88;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_dims(cfg_w[ph], cfg_h[ph]);
      wd = int'(sat_dim(cfg_w[ph]));
      hd = int'(sat_dim(cfg_h[ph]));
      for (int n = 0; n < RandPerPhase; n++) begin
        k = $urandom_range(9);
        r = $urandom_range(hd - 1);
        c = $urandom_range(wd - 1);
        case (k)
          0: begin
            r = $urandom_range(1023);
            c = $urandom_range(1023);
          end
          1: c = r + $urandom_range(2) - 1;
          2: c = wd - 1 - r + $urandom_range(2) - 1;
          3: c = wd / 2 - (r - hd / 2) + $urandom_range(2) - 1;
          4: c = wd / 2 + (r - hd / 2) + $urandom_range(2) - 1;
          default: ;
        endcase
        push_pixel(r, c);
      end
      if (ph == 6) holdoff_go = 1'b1;
      wait_drained();
    end

    if (fail_cnt == 0) begin
      $display("tb_triangle_poly_warp_address OK");
    end else begin
      $display("tb_triangle_poly_warp_address NOT OK");
    end
    $finish;
  end

endmodule
